>>> rtl/quoted_line_tokenizer_assert.svh
`ifndef QUOTED_LINE_TOKENIZER_ASSERT_SVH
`define QUOTED_LINE_TOKENIZER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define QLT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qlt check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define QLT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qlt check failed");

`endif

>>> rtl/qlt_pkg.sv
package qlt_pkg;

	localparam int LINE_CAPACITY = 256;
	localparam int MAX_TOKENS    = 16;

	localparam int LEN_W   = $clog2(LINE_CAPACITY);
	localparam int SEEN_W  = $clog2(MAX_TOKENS + 1);
	localparam int BYTE_W  = 8;
	localparam int INDEX_W = 4;
	localparam int COUNT_W = 5;
	localparam int OUT_W   = 24;

	localparam logic [BYTE_W-1:0] BYTE_NUL   = 8'h00;
	localparam logic [BYTE_W-1:0] BYTE_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] BYTE_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] BYTE_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] BYTE_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] BYTE_QUOTE = 8'h22;

	typedef enum logic [1:0] {
		KIND_CHAR      = 2'd0,
		KIND_TOKEN_END = 2'd1,
		KIND_LINE_END  = 2'd2,
		KIND_DROPPED   = 2'd3
	} kind_t;

	typedef struct packed {
		logic                 valid;
		kind_t                kind;
		logic [BYTE_W-1:0]    token_char;
		logic [INDEX_W-1:0]   token_index;
		logic [COUNT_W-1:0]   token_count;
	} res_t;

endpackage

>>> rtl/qlt_core.sv
module qlt_core
	import qlt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [BYTE_W-1:0] rx_byte,
	output res_t              res
);

	logic [LEN_W-1:0]  line_length_q;
	logic              inside_token_q;
	logic              inside_quotes_q;
	logic [SEEN_W-1:0] tokens_seen_q;
	logic              ignore_rest_q;

	logic [LEN_W-1:0]  line_length_d;
	logic              inside_token_d;
	logic              inside_quotes_d;
	logic [SEEN_W-1:0] tokens_seen_d;
	logic              ignore_rest_d;

	always_comb begin
		logic              sep;
		logic              quoted;
		logic [SEEN_W-1:0] seen;
		logic [LEN_W:0]    len_inc;

		sep     = (rx_byte == BYTE_SPACE) || (rx_byte == BYTE_TAB);
		len_inc = {1'b0, line_length_q} + (LEN_W+1)'(1);
		quoted  = inside_quotes_q;
		seen    = tokens_seen_q;

		res             = '0;
		res.kind        = KIND_CHAR;
		line_length_d   = line_length_q;
		inside_token_d  = inside_token_q;
		inside_quotes_d = inside_quotes_q;
		tokens_seen_d   = tokens_seen_q;
		ignore_rest_d   = ignore_rest_q;

		if (rx_byte == BYTE_LF) begin
			line_length_d   = '0;
			inside_token_d  = 1'b0;
			inside_quotes_d = 1'b0;
			tokens_seen_d   = '0;
			ignore_rest_d   = 1'b0;
			if (tokens_seen_q != '0) begin
				res.valid       = 1'b1;
				res.kind        = KIND_LINE_END;
				res.token_count = COUNT_W'(tokens_seen_q);
			end
		end else if (rx_byte == BYTE_CR) begin
			res.valid = 1'b0;
		end else if (len_inc >= (LEN_W+1)'(LINE_CAPACITY)) begin
			line_length_d   = '0;
			inside_token_d  = 1'b0;
			inside_quotes_d = 1'b0;
			tokens_seen_d   = '0;
			ignore_rest_d   = 1'b0;
			res.valid       = 1'b1;
			res.kind        = KIND_DROPPED;
		end else begin
			line_length_d = len_inc[LEN_W-1:0];
			if (ignore_rest_q) begin
				res.valid = 1'b0;
			end else if (rx_byte == BYTE_NUL) begin
				ignore_rest_d = 1'b1;
			end else if (!inside_token_q && sep) begin
				res.valid = 1'b0;
			end else if (inside_token_q && sep && !inside_quotes_q) begin
				inside_token_d  = 1'b0;
				inside_quotes_d = 1'b0;
				if (tokens_seen_q >= SEEN_W'(MAX_TOKENS))
					ignore_rest_d = 1'b1;
				res.valid       = 1'b1;
				res.kind        = KIND_TOKEN_END;
				res.token_index = INDEX_W'(tokens_seen_q - SEEN_W'(1));
			end else begin
				if (!inside_token_q) begin
					quoted         = 1'b0;
					seen           = tokens_seen_q + SEEN_W'(1);
					inside_token_d = 1'b1;
					tokens_seen_d  = seen;
				end
				if (rx_byte == BYTE_QUOTE) begin
					inside_quotes_d = !quoted;
				end else begin
					inside_quotes_d = quoted;
					res.valid       = 1'b1;
					res.kind        = KIND_CHAR;
					res.token_char  = rx_byte;
					res.token_index = INDEX_W'(seen - SEEN_W'(1));
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q   <= '0;
			inside_token_q  <= 1'b0;
			inside_quotes_q <= 1'b0;
			tokens_seen_q   <= '0;
			ignore_rest_q   <= 1'b0;
		end else if (step) begin
			line_length_q   <= line_length_d;
			inside_token_q  <= inside_token_d;
			inside_quotes_q <= inside_quotes_d;
			tokens_seen_q   <= tokens_seen_d;
			ignore_rest_q   <= ignore_rest_d;
		end
	end

endmodule

>>> rtl/quoted_line_tokenizer.sv
// Splits a console byte stream into newline-framed lines of tokens. Space and tab separate
// tokens outside double quotes; quotes are stripped, CR is ignored, and a NUL or the end of
// the last allowed token mutes the rest of the line. Each accepted byte gives at most one
// output beat: a token character, a token end, a line end with the token count (empty lines
// give none), or a line-dropped mark on overflow. One byte is taken every cycle while the
// output is not stalled; the line state is computed combinationally and registered as each
// byte advances, so the rate is one byte per clock. A byte waits in the input register, and
// its beat is then held in the output register until accepted; an output stall holds both.
module quoted_line_tokenizer
	import qlt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [BYTE_W-1:0] s_tdata,  // [7:0] rx_byte
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,  // [7:0] token_char, [11:8] token_index, [16:12] token_count
	output logic [1:0]        m_tuser   // [1:0] kind
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              out_free;
	logic              advance;
	res_t              res;
	logic              m_tvalid_q;
	kind_t             kind_q;
	logic [BYTE_W-1:0] char_q;
	logic [INDEX_W-1:0] index_q;
	logic [COUNT_W-1:0] count_q;

	assign out_free = !m_tvalid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			byte_s1 <= s_tdata;
	end

	qlt_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_free) begin
			m_tvalid_q <= advance && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			kind_q  <= res.kind;
			char_q  <= res.token_char;
			index_q <= res.token_index;
			count_q <= res.token_count;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = kind_q;
	assign m_tdata  = {(OUT_W-BYTE_W-INDEX_W-COUNT_W)'(0), count_q, index_q, char_q};

endmodule

>>> rtl/qlt_checker.sv
`include "quoted_line_tokenizer_assert.svh"

module qlt_checker
	import qlt_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [OUT_W-1:0]  m_tdata,
	input logic [1:0]        m_tuser
);

	// held beat stays up and unchanged
	`QLT_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	`QLT_ASSERT_IMP(a_pad, m_tvalid, m_tdata[OUT_W-1:17] == '0)

	`QLT_ASSERT_IMP(a_line_end, m_tvalid && (m_tuser == KIND_LINE_END),
		(m_tdata[16:12] != '0) && (m_tdata[11:0] == '0))

	`QLT_ASSERT_IMP(a_token_beat, m_tvalid && ((m_tuser == KIND_CHAR) || (m_tuser == KIND_TOKEN_END)),
		m_tdata[16:12] == '0)

	`QLT_ASSERT_IMP(a_dropped, m_tvalid && (m_tuser == KIND_DROPPED), m_tdata == '0)

endmodule

bind quoted_line_tokenizer qlt_checker u_qlt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
